FILE: rtl/owtr_pkg.sv
// Shared types and constants for the 1-Wire temperature reader.
package owtr_pkg;

    localparam int TIMER_W     = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_GAP      = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_REL   = 4'd6,
        PH_CONV     = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_RD_REL   = 4'd9
    } phase_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LOW     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_GAP   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CONVERSION    = 3'd6;

    // Command bytes in bus order: skip-ROM, convert, skip-ROM, read-scratchpad
    localparam logic [3:0][7:0] CMD_BYTES = {8'hBE, 8'hCC, 8'h44, 8'hCC};

    // Byte counts where the sequence turns
    localparam logic [2:0] BYTE_CONV_AT = 3'd2;
    localparam logic [2:0] BYTE_READ_AT = 3'd4;
    localparam logic [2:0] BYTE_END_AT  = 3'd6;

    // Result item, drive_low in bit 0
    typedef struct packed {
        logic [15:0] temperature_raw;
        logic        no_device;
        logic        done_res;
        logic        busy_res;
        logic        drive_low;
    } result_t;

endpackage

FILE: rtl/onewire_temperature_reader.sv
// 1-Wire bus master that runs a full temperature read per start request.
//
// Channel   Dir  Transfer when          Payload
// s_*       in   s_tvalid & s_tready    tuser: kind; tdata[0]: line_level
// m_*       out  m_tvalid & m_tready    tdata: drive_low, busy_res, done_res,
//                                       no_device, temperature_raw[15:0]
// cfg_*     in   cfg_we                 cfg_index selects, cfg_data value
//
// One input item per clock while s_tready is high. Each item updates the
// sequencer state when accepted; its result is registered in output or skid.
// A skid register behind the output register keeps s_tready high while one
// result waits; s_tready drops only when both are full.
// rst_n (async, active low) clears sequencer state and restores register
// defaults; results in flight are dropped.
module onewire_temperature_reader
    import owtr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] line_level, [7:1] zero
    input  logic                   s_tuser,   // [0] kind: 0 tick, 1 start
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [0] drive_low, [1] busy_res,
                                              // [2] done_res, [3] no_device,
                                              // [19:4] temperature_raw, rest 0
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // timing registers
    logic [9:0]  reset_low_time_reg;
    logic [9:0]  presence_wait_time_reg;
    logic [9:0]  reset_tail_time_reg;
    logic [7:0]  slot_time_reg;
    logic [3:0]  short_low_time_reg;
    logic [15:0] command_gap_time_reg;
    logic [19:0] conversion_time_reg;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] phase_timer_reg, phase_timer_next;
    logic [2:0]         bit_position_reg, bit_position_next;
    logic [2:0]         byte_step_reg, byte_step_next;
    logic [15:0]        read_shift_reg, read_shift_next;
    logic               absent_flag_reg, absent_flag_next;
    logic               done_next;

    // output and skid registers
    result_t out_data_reg, skid_data_reg, result_next;
    logic    out_valid_reg, skid_valid_reg;

    logic s_accept;
    logic kind;
    logic line_level;

    assign kind       = s_tuser;
    assign line_level = s_tdata[0];
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_time_reg     <= 10'd400;
            presence_wait_time_reg <= 10'd80;
            reset_tail_time_reg    <= 10'd400;
            slot_time_reg          <= 8'd50;
            short_low_time_reg     <= 4'd1;
            command_gap_time_reg   <= 16'd1000;
            conversion_time_reg    <= 20'd800000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RESET_LOW:     reset_low_time_reg     <= cfg_data[9:0];
                REG_PRESENCE_WAIT: presence_wait_time_reg <= cfg_data[9:0];
                REG_RESET_TAIL:    reset_tail_time_reg    <= cfg_data[9:0];
                REG_SLOT:          slot_time_reg          <= cfg_data[7:0];
                REG_SHORT_LOW:     short_low_time_reg     <= cfg_data[3:0];
                REG_COMMAND_GAP:   command_gap_time_reg   <= cfg_data[15:0];
                REG_CONVERSION:    conversion_time_reg    <= cfg_data[19:0];
                default:           ;
            endcase
        end
    end

    // Next sequencer state for the item at the input. The timer advances on
    // every tick; entering a phase clears it. A zero duration ends on the
    // first tick since the timer is already 1 by then.
    always_comb
    begin
        logic [TIMER_W-1:0] tmr;
        logic [2:0]         byte_inc;
        logic               cur_bit;
        logic               wr_bit_done;

        phase_next        = phase_reg;
        phase_timer_next  = phase_timer_reg;
        bit_position_next = bit_position_reg;
        byte_step_next    = byte_step_reg;
        read_shift_next   = read_shift_reg;
        absent_flag_next  = absent_flag_reg;
        done_next         = 1'b0;

        tmr         = phase_timer_reg + TIMER_W'(1);
        byte_inc    = byte_step_reg + 3'd1;
        cur_bit     = CMD_BYTES[byte_step_reg[1:0]][bit_position_reg];
        wr_bit_done = 1'b0;

        if (kind)
        begin
            if (phase_reg == PH_IDLE)
            begin
                bit_position_next = '0;
                byte_step_next    = '0;
                read_shift_next   = '0;
                absent_flag_next  = 1'b0;
                phase_next        = PH_RST_LOW;
                phase_timer_next  = '0;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            phase_timer_next = tmr;
            case (phase_reg)
                PH_RST_LOW:
                    if (tmr >= TIMER_W'(reset_low_time_reg))
                    begin
                        phase_next       = PH_RST_WAIT;
                        phase_timer_next = '0;
                    end
                PH_RST_WAIT:
                    if (tmr >= TIMER_W'(presence_wait_time_reg))
                    begin
                        // line still high at the sample: nobody answered
                        if (line_level)
                            absent_flag_next = 1'b1;
                        phase_next       = PH_RST_TAIL;
                        phase_timer_next = '0;
                    end
                PH_RST_TAIL:
                    if (tmr >= TIMER_W'(reset_tail_time_reg))
                    begin
                        phase_next       = PH_GAP;
                        phase_timer_next = '0;
                    end
                PH_GAP:
                    if (tmr >= TIMER_W'(command_gap_time_reg))
                    begin
                        phase_next       = PH_WR_LOW;
                        phase_timer_next = '0;
                    end
                PH_WR_LOW:
                    if (cur_bit)
                    begin
                        if (tmr >= TIMER_W'(short_low_time_reg))
                        begin
                            phase_next       = PH_WR_REL;
                            phase_timer_next = '0;
                        end
                    end
                    else if (tmr >= TIMER_W'(slot_time_reg))
                        wr_bit_done = 1'b1;
                PH_WR_REL:
                    if (tmr >= TIMER_W'(slot_time_reg))
                        wr_bit_done = 1'b1;
                PH_CONV:
                    if (tmr >= conversion_time_reg)
                    begin
                        phase_next       = PH_RST_LOW;
                        phase_timer_next = '0;
                    end
                PH_RD_LOW:
                    if (tmr >= TIMER_W'(short_low_time_reg))
                    begin
                        phase_next       = PH_RD_REL;
                        phase_timer_next = '0;
                    end
                PH_RD_REL:
                begin
                    // sample on the first released tick
                    if (tmr == TIMER_W'(1) && line_level)
                        read_shift_next[{byte_step_reg[0], bit_position_reg}] = 1'b1;
                    if (tmr >= TIMER_W'(slot_time_reg))
                    begin
                        phase_next       = PH_RD_LOW;
                        phase_timer_next = '0;
                        if (bit_position_reg == 3'd7)
                        begin
                            bit_position_next = '0;
                            byte_step_next    = byte_inc;
                            if (byte_inc >= BYTE_END_AT)
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                        end
                        else
                            bit_position_next = bit_position_reg + 3'd1;
                    end
                end
                default:
                begin
                    phase_next       = PH_IDLE;
                    phase_timer_next = '0;
                end
            endcase

            // end of a written bit: next bit, next byte, or leave the command
            if (wr_bit_done)
            begin
                phase_timer_next = '0;
                if (bit_position_reg == 3'd7)
                begin
                    bit_position_next = '0;
                    byte_step_next    = byte_inc;
                    if (byte_inc == BYTE_CONV_AT)
                        phase_next = PH_CONV;
                    else if (byte_inc >= BYTE_READ_AT)
                        phase_next = PH_RD_LOW;
                    else
                        phase_next = PH_WR_LOW;
                end
                else
                begin
                    bit_position_next = bit_position_reg + 3'd1;
                    phase_next        = PH_WR_LOW;
                end
            end
        end

        result_next.drive_low       = (phase_next == PH_RST_LOW) ||
                                      (phase_next == PH_WR_LOW)  ||
                                      (phase_next == PH_RD_LOW);
        result_next.busy_res        = (phase_next != PH_IDLE);
        result_next.done_res        = done_next;
        result_next.no_device       = absent_flag_next;
        result_next.temperature_raw = read_shift_next;
    end

    // state commits on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            phase_timer_reg  <= '0;
            bit_position_reg <= '0;
            byte_step_reg    <= '0;
            read_shift_reg   <= '0;
            absent_flag_reg  <= 1'b0;
        end
        else if (s_accept)
        begin
            phase_reg        <= phase_next;
            phase_timer_reg  <= phase_timer_next;
            bit_position_reg <= bit_position_next;
            byte_step_reg    <= byte_step_next;
            read_shift_reg   <= read_shift_next;
            absent_flag_reg  <= absent_flag_next;
        end
    end

    // output register with skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= s_accept;
        end
        else if (s_accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (s_accept)
                out_data_reg <= result_next;
        end
        else if (s_accept)
            skid_data_reg <= result_next;
    end

    // skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output register empty");

    // idle always has a cleared timer
    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (phase_timer_reg == '0))
        else $error("timer running while idle");

    // byte counter never passes the end of the sequence
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_step_reg != 3'd7)
        else $error("byte counter out of range");

    // a start accepted while idle opens the reset pulse
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && kind && phase_reg == PH_IDLE) |=> (phase_reg == PH_RST_LOW))
        else $error("start did not launch reset pulse");

endmodule

FILE: tb/tb_onewire_temperature_reader.sv
// Self-checking testbench for the 1-Wire temperature reader sequencer.
`timescale 1ns / 100ps

module tb_onewire_temperature_reader;
    import owtr_pkg::*;

    // Input kinds carried on s_tuser
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Index past the register list, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    // Line level flavor of a burst of ticks
    localparam int LVL_RANDOM = 0;
    localparam int LVL_LOW    = 1;
    localparam int LVL_HIGH   = 2;

    localparam int IDLE_PCT  = 7;
    localparam int BURST_LEN = 32;

    typedef struct packed {
        logic kind;
        logic lvl;
    } bus_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;    // [0] line_level, [7:1] zero
    logic                   s_tuser = 1'b0;    // [0] kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;           // [0] drive_low, [1] busy_res,
                                               // [2] done_res, [3] no_device,
                                               // [19:4] temperature_raw
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    onewire_temperature_reader i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer model: own copy of timing registers and state
    // ------------------------------------------------------------------
    logic [9:0]  t_rst_low;
    logic [9:0]  t_presence;
    logic [9:0]  t_rst_tail;
    logic [7:0]  t_slot;
    logic [3:0]  t_short;
    logic [15:0] t_gap;
    logic [19:0] t_conv;

    phase_t      ph;
    logic [19:0] tmr;
    logic [2:0]  bpos;
    logic [2:0]  bstep;
    logic [15:0] temp_bits;
    logic        absent;

    bus_item_t   pending_bus_items[$];
    result_t     predicted_results[$];

    int          reads_done = 0;
    int          absent_reads = 0;
    int          xfers_in = 0;
    int          settings_used = 0;
    int          fails = 0;
    logic [31:0] cycle_cnt = 0;
    logic        calm;

    // While cycle_cnt[9:8] is 2'b11 the run goes with no idling on either side
    assign calm = (cycle_cnt[9:8] == 2'b11);

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic void set_phase(input phase_t p);
        ph  = p;
        tmr = '0;
    endfunction

    // One command bit finished: next bit, next byte, or leave the write part
    function automatic void write_slot_done();
        if (bpos == 3'd7)
        begin
            bpos  = '0;
            bstep = bstep + 3'd1;
            if (bstep == BYTE_CONV_AT)
                set_phase(PH_CONV);
            else if (bstep >= BYTE_READ_AT)
                set_phase(PH_RD_LOW);
            else
                set_phase(PH_WR_LOW);
        end
        else
        begin
            bpos = bpos + 3'd1;
            set_phase(PH_WR_LOW);
        end
    endfunction

    // Advance by one microsecond tick; returns 1 when the whole read ends
    function automatic logic bus_tick(input logic lvl);
        logic fin;
        logic wbit;
        fin  = 1'b0;
        wbit = CMD_BYTES[bstep[1:0]][bpos];
        tmr  = tmr + 20'd1;
        case (ph)
            PH_RST_LOW:  if (tmr >= t_rst_low) set_phase(PH_RST_WAIT);
            PH_RST_WAIT:
                if (tmr >= t_presence)
                begin
                    // line still high at the sample: nobody answered
                    if (lvl)
                        absent = 1'b1;
                    set_phase(PH_RST_TAIL);
                end
            PH_RST_TAIL: if (tmr >= t_rst_tail) set_phase(PH_GAP);
            PH_GAP:      if (tmr >= t_gap) set_phase(PH_WR_LOW);
            PH_WR_LOW:
                if (tmr >= (wbit ? {4'd0, t_short} : t_slot))
                begin
                    if (wbit)
                        set_phase(PH_WR_REL);
                    else
                        write_slot_done();   // write-0 has no recovery
                end
            PH_WR_REL:   if (tmr >= t_slot) write_slot_done();
            PH_CONV:     if (tmr >= t_conv) set_phase(PH_RST_LOW);
            PH_RD_LOW:   if (tmr >= t_short) set_phase(PH_RD_REL);
            PH_RD_REL:
            begin
                // sampled on the first released tick only
                if (tmr == 20'd1 && lvl)
                    temp_bits[{bstep[0], bpos}] = 1'b1;
                if (tmr >= t_slot)
                begin
                    if (bpos == 3'd7)
                    begin
                        bpos  = '0;
                        bstep = bstep + 3'd1;
                        if (bstep >= BYTE_END_AT)
                        begin
                            set_phase(PH_IDLE);
                            fin = 1'b1;
                        end
                        else
                            set_phase(PH_RD_LOW);
                    end
                    else
                    begin
                        bpos = bpos + 3'd1;
                        set_phase(PH_RD_LOW);
                    end
                end
            end
            default:     set_phase(PH_IDLE);
        endcase
        return fin;
    endfunction

    // Result expected for one accepted input transfer
    function automatic result_t bus_step(input logic kind, input logic lvl);
        result_t r;
        logic    fin;
        fin = 1'b0;
        if (kind == KIND_START)
        begin
            // a start while busy is dropped
            if (ph == PH_IDLE)
            begin
                bpos      = '0;
                bstep     = '0;
                temp_bits = '0;
                absent    = 1'b0;
                set_phase(PH_RST_LOW);
            end
        end
        else if (ph != PH_IDLE)
            fin = bus_tick(lvl);
        r.drive_low       = (ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW);
        r.busy_res        = (ph != PH_IDLE);
        r.done_res        = fin;
        r.no_device       = absent;
        r.temperature_raw = temp_bits;
        if (fin)
        begin
            reads_done++;
            if (absent)
                absent_reads++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: pulls from the pending queue, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drv
        bus_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_results.push_back(bus_step(s_tuser, s_tdata[0]));
                xfers_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bus_items.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_bus_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.kind;
                    s_tdata  <= {7'd0, nxt.lvl};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: in-order compare against the predicted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[19:0]);
                if (predicted_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transfer %h at %0t", m_tdata, $realtime);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.drive_low != want.drive_low || got.busy_res != want.busy_res ||
                        got.done_res != want.done_res || got.no_device != want.no_device ||
                        got.temperature_raw != want.temperature_raw ||
                        m_tdata[23:20] != 4'd0)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $write("mismatch at %0t: exp low=%b busy=%b done=%b nodev=%b temp=%h",
                                   $realtime, want.drive_low, want.busy_res,
                                   want.done_res, want.no_device, want.temperature_raw);
                            $display(" | got low=%b busy=%b done=%b nodev=%b temp=%h pad=%h",
                                     got.drive_low, got.busy_res, got.done_res,
                                     got.no_device, got.temperature_raw, m_tdata[23:20]);
                        end
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_RESET_LOW:     t_rst_low  = val[9:0];
            REG_PRESENCE_WAIT: t_presence = val[9:0];
            REG_RESET_TAIL:    t_rst_tail = val[9:0];
            REG_SLOT:          t_slot     = val[7:0];
            REG_SHORT_LOW:     t_short    = val[3:0];
            REG_COMMAND_GAP:   t_gap      = val[15:0];
            REG_CONVERSION:    t_conv     = val[19:0];
            default:           ;
        endcase
    endtask

    task automatic load_timing(input logic [CFG_DATA_W-1:0] rl, input logic [CFG_DATA_W-1:0] pw,
                               input logic [CFG_DATA_W-1:0] rt, input logic [CFG_DATA_W-1:0] sl,
                               input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] gp,
                               input logic [CFG_DATA_W-1:0] cv);
        write_reg(REG_RESET_LOW, rl);
        write_reg(REG_PRESENCE_WAIT, pw);
        write_reg(REG_RESET_TAIL, rt);
        write_reg(REG_SLOT, sl);
        write_reg(REG_SHORT_LOW, sh);
        write_reg(REG_COMMAND_GAP, gp);
        write_reg(REG_CONVERSION, cv);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic push_item(input logic kind, input logic lvl);
        bus_item_t it;
        it.kind = kind;
        it.lvl  = lvl;
        pending_bus_items.push_back(it);
    endtask

    // A burst of ticks with the odd start; the line flavor is picked per burst
    // so that presence samples see both a device and an empty bus.
    task automatic push_burst(input bit starts_ok);
        int  mode;
        logic lvl;
        mode = $urandom_range(2);
        for (int i = 0; i < BURST_LEN; i++)
        begin
            case (mode)
                LVL_RANDOM: lvl = 1'($urandom_range(1));
                LVL_LOW:    lvl = ($urandom_range(19) == 0);
                LVL_HIGH:   lvl = ($urandom_range(19) != 0);
                default:    lvl = 1'b0;
            endcase
            if (starts_ok && $urandom_range(39) == 0)
                push_item(KIND_START, lvl);
            else
                push_item(KIND_TICK, lvl);
        end
    endtask

    // Block idle on both streams with nothing outstanding
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_bus_items.size() != 0 || s_tvalid || predicted_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Keep the input fed until the given number of reads finished, then
    // tick without starts until the sequencer is idle again.
    task automatic run_reads(input int goal);
        int base;
        base = reads_done;
        while (reads_done - base < goal)
        begin
            while (pending_bus_items.size() > 8)
                @(posedge clk);
            push_burst(1'b1);
        end
        wait_quiet();
        while (ph != PH_IDLE)
        begin
            push_burst(1'b0);
            wait_quiet();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stim
        t_rst_low  = 10'd400;
        t_presence = 10'd80;
        t_rst_tail = 10'd400;
        t_slot     = 8'd50;
        t_short    = 4'd1;
        t_gap      = 16'd1000;
        t_conv     = 20'd800000;
        ph         = PH_IDLE;
        tmr        = '0;
        bpos       = '0;
        bstep      = '0;
        temp_bits  = '0;
        absent     = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero everywhere: every interval collapses to one tick.
        // A write past the register list must leave all timing alone.
        write_reg(REG_UNUSED, '1);
        load_timing('0, '0, '0, '0, '0, '0, '0);

        // Directed: ticks while idle, a start, a start while busy, then
        // ticks through the first reset with both line levels.
        push_item(KIND_TICK, 1'b0);
        push_item(KIND_TICK, 1'b1);
        push_item(KIND_START, 1'b1);
        push_item(KIND_START, 1'b0);
        for (int i = 0; i < 20; i++)
            push_item(KIND_TICK, i[1]);
        run_reads(3);

        // Short random timings, including zeros and short low above slot
        for (int k = 0; k < 2; k++)
        begin
            load_timing(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 6)),
                        CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 4)),
                        CFG_DATA_W'($urandom_range(0, 4)), CFG_DATA_W'($urandom_range(0, 6)),
                        CFG_DATA_W'($urandom_range(0, 10)));
            run_reads(1);
        end

        // Every register at its maximum, masked to each register's width;
        // far too long to finish, so only the opening of the sequence is run.
        load_timing('1, '1, '1, '1, '1, '1, '1);
        push_item(KIND_START, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            while (pending_bus_items.size() > 8)
                @(posedge clk);
            push_burst(1'b1);
        end

        wait_quiet();
        repeat (20) @(posedge clk);

        $display("covered %0d input transfers over %0d timing settings", xfers_in, settings_used);
        $display("%0d complete reads, %0d of them with no device answering",
                 reads_done, absent_reads);
        if (fails == 0 && predicted_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
